// ----- hdl/voxel_grain_surface_select_macros.svh -----
// assertion macros shared by the voxel grain surface select rtl
`ifndef VOXEL_GRAIN_SURFACE_SELECT_MACROS_SVH
`define VOXEL_GRAIN_SURFACE_SELECT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define VGSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define VGSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VGSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VGSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/vgss_pkg.sv -----
// shared types and constants of the voxel grain surface select block
`default_nettype none

package vgss_pkg;

  // fixed field widths of the stream and register port
  localparam int POS_W   = 6;
  localparam int GID_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int SIZE_W  = 7;
  localparam int NUC_W   = 16;
  localparam int COLOR_W = 18;
  localparam int EFF_W   = 9;
  localparam int PADDR_W = 5;

  // color offset for ids above the nucleus count
  localparam int GRAIN_OFFSET = 500 * 500 / 2;

  // request kinds
  typedef enum logic [1:0] {
    REQ_WR_VOXEL = 2'd0,
    REQ_WR_HIDE  = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_NONE     = 2'd3
  } req_kind_t;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_SIZE_X   = 5'h00;
  localparam logic [PADDR_W-1:0] ADDR_SIZE_Y   = 5'h04;
  localparam logic [PADDR_W-1:0] ADDR_SIZE_Z   = 5'h08;
  localparam logic [PADDR_W-1:0] ADDR_NUCLEUS  = 5'h0c;
  localparam logic [PADDR_W-1:0] ADDR_SHOW     = 5'h10;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic [NUC_W-1:0]  nucleus_count;
    logic              show_grains;
  } cfg_t;

  typedef struct packed {
    req_kind_t         req_type;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [GID_W-1:0]  grain_id;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
  } item_t;

  typedef struct packed {
    logic               draw;
    logic [COLOR_W-1:0] color_index;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              used;
  } hide_wr_t;

endpackage

`default_nettype wire

// ----- hdl/vgss_ram.sv -----
// generic single port ram with registered read
`default_nettype none

module vgss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata <= mem_r[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vgss_hide.sv -----
// hidden id table with parallel match
`default_nettype none

module vgss_hide #(
  parameter int SLOTS = 8,
  parameter int IDW   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vgss_pkg::hide_wr_t wr,
  input  wire logic [IDW-1:0]    wr_id,
  input  wire logic [IDW-1:0]    match_id,
  output logic                   hit
);
  import vgss_pkg::*;

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP = SLOT_W + 4;

  logic [IDW-1:0] ids_r [SLOTS];
  logic [SLOTS-1:0] used_r;
  logic             in_range;
  logic [SW-1:0]    wr_idx;

  assign in_range = CMP'(wr.slot) < CMP'(SLOTS);
  assign wr_idx   = SW'(wr.slot);

  // used bits reset clear, ids need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en && in_range) begin
      used_r[wr_idx] <= wr.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && in_range) begin
      ids_r[wr_idx] <= wr_id;
    end
  end

  // any used slot holding the id
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used_r[i] && (ids_r[i] == match_id)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vgss_ctrl.sv -----
// query sequencer: voxel writes, center read, neighbor scan, result
`default_nettype none

module vgss_ctrl #(
  parameter int MAX_DIM = 64,
  parameter int IDW     = 16,
  parameter int AW      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_acc,
  input  wire vgss_pkg::item_t   item,
  input  wire vgss_pkg::cfg_t    cfg,
  output logic                   item_ready,
  output logic                   ram_en,
  output logic                   ram_we,
  output logic [3*AW-1:0]        ram_addr,
  output logic [IDW-1:0]         ram_wdata,
  input  wire logic [IDW-1:0]    ram_rdata,
  input  wire logic              hide_hit,
  output logic                   res_valid,
  output vgss_pkg::res_t         res,
  input  wire logic              res_ready
);
  import vgss_pkg::*;

  localparam int NW = (IDW > NUC_W) ? IDW : NUC_W;
  localparam int SW = (IDW > COLOR_W) ? IDW : COLOR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    x_r, y_r, z_r;
  logic             in_grid_r, face_r, vis_r, iss_r, pend_r;
  logic [1:0]       dx_r, dy_r, dz_r;
  logic [IDW-1:0]   id_r;

  logic [EFF_W-1:0] eff_x, eff_y, eff_z, px, py, pz;
  logic             in_grid, face, in_store;
  logic [AW:0]      nx, ny, nz;
  logic             is_grain;
  logic [SW-1:0]    id_ext, id_sum;

  // sizes above the store extent act as the extent
  assign eff_x = (EFF_W'(cfg.size_x) > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM) : EFF_W'(cfg.size_x);
  assign eff_y = (EFF_W'(cfg.size_y) > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM) : EFF_W'(cfg.size_y);
  assign eff_z = (EFF_W'(cfg.size_z) > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM) : EFF_W'(cfg.size_z);
  assign px = EFF_W'(item.pos_x);
  assign py = EFF_W'(item.pos_y);
  assign pz = EFF_W'(item.pos_z);

  assign in_grid  = (px < eff_x) && (py < eff_y) && (pz < eff_z);
  assign face     = (px == '0) || (py == '0) || (pz == '0) ||
                    (px == eff_x - 1'b1) || (py == eff_y - 1'b1) || (pz == eff_z - 1'b1);
  assign in_store = (px < EFF_W'(MAX_DIM)) && (py < EFF_W'(MAX_DIM)) &&
                    (pz < EFF_W'(MAX_DIM));

  // neighbor coordinate, offsets 0..2 stand for -1..+1
  assign nx = (AW+1)'(x_r) + (AW+1)'(dx_r) - 1'b1;
  assign ny = (AW+1)'(y_r) + (AW+1)'(dy_r) - 1'b1;
  assign nz = (AW+1)'(z_r) + (AW+1)'(dz_r) - 1'b1;

  assign item_ready = (state_r == ST_IDLE);

  // ram port: writes and center reads at accept, neighbor reads while scanning
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {AW'(item.pos_x), AW'(item.pos_y), AW'(item.pos_z)};
    ram_wdata = IDW'(item.grain_id);
    if (item_acc && (item.req_type == REQ_WR_VOXEL) && in_store) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
    end else if (item_acc && (item.req_type == REQ_QUERY)) begin
      ram_en = 1'b1;
    end else if ((state_r == ST_SCAN) && iss_r) begin
      ram_en   = 1'b1;
      ram_addr = {nx[AW-1:0], ny[AW-1:0], nz[AW-1:0]};
    end
  end

  // sequencer and its registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
      vis_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (item_acc && (item.req_type == REQ_QUERY)) begin
            x_r       <= AW'(item.pos_x);
            y_r       <= AW'(item.pos_y);
            z_r       <= AW'(item.pos_z);
            in_grid_r <= in_grid;
            face_r    <= face;
            state_r   <= ST_CENTER;
          end
        end
        ST_CENTER: begin
          id_r <= ram_rdata;
          if (!in_grid_r || hide_hit) begin
            vis_r   <= 1'b0;
            state_r <= ST_DONE;
          end else if (face_r) begin
            vis_r   <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            iss_r   <= 1'b1;
            pend_r  <= 1'b0;
            dx_r    <= '0;
            dy_r    <= '0;
            dz_r    <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r <= iss_r;
          // a differing neighbor ends the scan early
          if (pend_r && (ram_rdata != id_r)) begin
            vis_r   <= 1'b1;
            iss_r   <= 1'b0;
            state_r <= ST_DONE;
          end else if (!iss_r) begin
            vis_r   <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            // step through the 3x3x3 block, z fastest
            if (dz_r == 2'd2) begin
              dz_r <= '0;
              if (dy_r == 2'd2) begin
                dy_r <= '0;
                if (dx_r == 2'd2) begin
                  iss_r <= 1'b0;
                end else begin
                  dx_r <= dx_r + 1'b1;
                end
              end else begin
                dy_r <= dy_r + 1'b1;
              end
            end else begin
              dz_r <= dz_r + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // grain test and color index
  assign is_grain = NW'(id_r) <= NW'(cfg.nucleus_count);
  assign id_ext   = SW'(id_r);
  assign id_sum   = id_ext + SW'(GRAIN_OFFSET);

  always_comb begin
    res_valid       = (state_r == ST_DONE);
    res.draw        = vis_r && (!is_grain || cfg.show_grains);
    res.color_index = '0;
    if (res.draw) begin
      res.color_index = is_grain ? id_ext[COLOR_W-1:0] : id_sum[COLOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/voxel_grain_surface_select.sv -----
// voxel grain surface select: one input item in, one output register
// voxel and hidden slot writes can follow back to back
// a query result reaches the output register from the center read alone when the voxel is
// out of grid, hidden or on the outer face, else after a scan (center plus up to 27 reads,
// one per cycle from the single port voxel ram); the next item waits for the result to be taken
// reset: sizes 64, nucleus count 0, show grains 1, no hidden slots; voxel ram not swept
`default_nettype none
`include "voxel_grain_surface_select_macros.svh"

module voxel_grain_surface_select #(
  parameter int MAX_DIM      = 64,
  parameter int HIDDEN_SLOTS = 8,
  parameter int ID_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: pos_x, pos_y, pos_z, grain_id, slot, slot_valid, zero pad
  input  wire logic [39:0] in_tdata,
  // in_tuser: req_type
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: draw, color_index, zero pad
  output logic [23:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import vgss_pkg::*;

  localparam int AW    = $clog2(MAX_DIM);
  localparam int DEPTH = 1 << (3 * AW);

  cfg_t          cfg_r;
  item_t         item;
  logic          in_acc, item_ready, cfg_wr;
  logic          ram_en, ram_we;
  logic [3*AW-1:0] ram_addr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;
  logic          hide_hit;
  hide_wr_t      hide_wr;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x        <= SIZE_W'(64);
      cfg_r.size_y        <= SIZE_W'(64);
      cfg_r.size_z        <= SIZE_W'(64);
      cfg_r.nucleus_count <= '0;
      cfg_r.show_grains   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        ADDR_SIZE_X:  cfg_r.size_x        <= cfg_pwdata[SIZE_W-1:0];
        ADDR_SIZE_Y:  cfg_r.size_y        <= cfg_pwdata[SIZE_W-1:0];
        ADDR_SIZE_Z:  cfg_r.size_z        <= cfg_pwdata[SIZE_W-1:0];
        ADDR_NUCLEUS: cfg_r.nucleus_count <= cfg_pwdata[NUC_W-1:0];
        ADDR_SHOW:    cfg_r.show_grains   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_SIZE_X:  cfg_prdata = 32'(cfg_r.size_x);
      ADDR_SIZE_Y:  cfg_prdata = 32'(cfg_r.size_y);
      ADDR_SIZE_Z:  cfg_prdata = 32'(cfg_r.size_z);
      ADDR_NUCLEUS: cfg_prdata = 32'(cfg_r.nucleus_count);
      ADDR_SHOW:    cfg_prdata = 32'(cfg_r.show_grains);
      default:      cfg_prdata = '0;
    endcase
  end

  // input unpack and transfer
  assign item.req_type   = req_kind_t'(in_tuser);
  assign item.pos_x      = in_tdata[5:0];
  assign item.pos_y      = in_tdata[11:6];
  assign item.pos_z      = in_tdata[17:12];
  assign item.grain_id   = in_tdata[33:18];
  assign item.slot       = in_tdata[36:34];
  assign item.slot_valid = in_tdata[37];

  assign in_tready = item_ready;
  assign in_acc    = in_tvalid && in_tready;

  // hidden table write
  assign hide_wr.en   = in_acc && (item.req_type == REQ_WR_HIDE);
  assign hide_wr.slot = item.slot;
  assign hide_wr.used = item.slot_valid;

  vgss_hide #(
    .SLOTS (HIDDEN_SLOTS),
    .IDW   (ID_BITS)
  ) u_hide (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (hide_wr),
    .wr_id    (ID_BITS'(item.grain_id)),
    .match_id (ram_rdata),
    .hit      (hide_hit)
  );

  vgss_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vgss_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDW     (ID_BITS),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_acc   (in_acc),
    .item       (item),
    .cfg        (cfg_r),
    .item_ready (item_ready),
    .ram_en     (ram_en),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .hide_hit   (hide_hit),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.color_index, out_r.draw};

  // checks
  `VGSS_ASSERT(a_ram_wr_src, clk, rst_n, !(ram_en && ram_we) || (in_acc && (item.req_type == REQ_WR_VOXEL)), "voxel ram written without a voxel write transfer")
  `VGSS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped while output stalled")
  `VGSS_ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc && (item.req_type == REQ_QUERY), !in_tready, "query transfer did not occupy the sequencer")
  `VGSS_ASSERT(a_out_src, clk, rst_n, !$rose(out_tvalid) || $past(res_valid), "output valid without a result")

endmodule

`default_nettype wire
